### hdl/bce_pkg.sv
// shared types, constants and log2 table builder for the column entropy core
package bce_pkg;

    localparam int LOG_FRAC        = 48;
    localparam int LOG_W           = 54;
    localparam int ROWS_W          = 7;
    localparam int ACC_W           = 29;
    localparam int COL_W           = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLUMNS = 4096;
    localparam int DEF_FRAC_BITS   = 16;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd64;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_COUNT,
        ENG_MUL,
        ENG_DIV,
        ENG_DONE
    } t_eng_state;

    // request from the stream side to the entropy engine
    typedef struct packed {
        logic              start;
        logic [ROWS_W-1:0] rows;
    } t_eng_req;

    typedef logic [LOG_W-1:0] t_log_tab [0:64];

    // (a * b) >> 62, evaluated only while building the table
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // log2(x) with LOG_FRAC fraction bits by repeated squaring
    function automatic logic [LOG_W-1:0] log2_fixed(input int unsigned x);
        logic [63:0] e;
        logic [63:0] y;
        logic [63:0] frac;
        e    = 64'd0;
        frac = 64'd0;
        if (x == 0) begin
            return '0;
        end
        for (int j = 0; j < 6; j++) begin
            if ((64'(x) >> (e + 64'd1)) != 64'd0) begin
                e = e + 64'd1;
            end
        end
        y = 64'(x) << (64'd62 - e);
        for (int i = 0; i < LOG_FRAC; i++) begin
            y    = mul_q62(y, y);
            frac = frac << 1;
            if (y >= (64'd1 << 63)) begin
                frac = frac | 64'd1;
                y    = y >> 1;
            end
        end
        return LOG_W'((e << LOG_FRAC) | frac);
    endfunction

    function automatic t_log_tab build_log_tab();
        t_log_tab t;
        for (int unsigned x = 0; x <= 64; x++) begin
            t[x] = log2_fixed(x);
        end
        return t;
    endfunction

endpackage

### hdl/bce_engine.sv
// sequenced entropy engine: popcount, shared multiplier, restoring divider
module bce_engine
    import bce_pkg::*;
#(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_eng_req             i_req,
    input  logic [COL_W-1:0]     i_bits,
    output logic                 o_done,
    output logic [FRAC_BITS+1:0] o_value
);

    localparam int QW  = FRAC_BITS + 2;
    localparam int SH  = LOG_FRAC - FRAC_BITS;
    localparam int DSW = ROWS_W + SH + QW - 1;
    localparam t_log_tab LOG_TAB = build_log_tab();
    localparam logic [ROWS_W-1:0] MROWS = ROWS_W'(MAX_ROWS);

    t_eng_state r_state, n_state;
    logic [COL_W-1:0]        r_bits;
    logic [ROWS_W-1:0]       r_k, r_m;
    logic [4:0]              r_cnt;
    logic [ROWS_W+LOG_W-1:0] r_prod;
    logic signed [62:0]      r_acc;
    logic [59:0]             r_rem;
    logic [DSW-1:0]          r_dsh;
    logic [QW-1:0]           r_q;

    logic [ROWS_W-1:0]       m_eff;
    logic [COL_W-1:0]        mask;
    logic [3:0]              pc;
    logic [ROWS_W-1:0]       mul_a;
    logic [LOG_W-1:0]        mul_b;
    logic                    is_const;

    // clamp the row count and build the row mask
    always_comb begin
        if (i_req.rows == '0) begin
            m_eff = ROWS_W'(1);
        end else if (i_req.rows > MROWS) begin
            m_eff = MROWS;
        end else begin
            m_eff = i_req.rows;
        end
        if (m_eff >= ROWS_W'(COL_W)) begin
            mask = '1;
        end else begin
            mask = (COL_W'(1) << m_eff) - COL_W'(1);
        end
    end

    // popcount of one byte per cycle
    always_comb begin
        pc = '0;
        for (int i = 0; i < 8; i++) begin
            pc = pc + 4'(r_bits[i]);
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_cnt)
            5'd0: begin
                mul_a = r_m;
                mul_b = LOG_TAB[r_m];
            end
            5'd1: begin
                mul_a = r_k;
                mul_b = LOG_TAB[r_k];
            end
            default: begin
                mul_a = r_m - r_k;
                mul_b = LOG_TAB[r_m - r_k];
            end
        endcase
    end

    assign is_const = (r_k == '0) || (r_k == r_m);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        unique case (r_state)
            ENG_IDLE: begin
                if (i_req.start) n_state = ENG_COUNT;
            end
            ENG_COUNT: begin
                if (r_cnt == 5'd7) n_state = ENG_MUL;
            end
            ENG_MUL: begin
                if (r_cnt == 5'd0 && is_const) begin
                    n_state = ENG_DONE;
                end else if (r_cnt == 5'd3) begin
                    n_state = ENG_DIV;
                end
            end
            ENG_DIV: begin
                if (r_cnt == 5'(QW - 1)) n_state = ENG_DONE;
            end
            ENG_DONE: begin
                o_done  = 1'b1;
                n_state = ENG_IDLE;
            end
            default: n_state = ENG_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (r_state)
                ENG_IDLE: begin
                    r_bits <= i_bits & mask;
                    r_m    <= m_eff;
                    r_k    <= '0;
                    r_cnt  <= '0;
                    r_q    <= '0;
                end
                ENG_COUNT: begin
                    r_k    <= r_k + ROWS_W'(pc);
                    r_bits <= r_bits >> 8;
                    r_cnt  <= (r_cnt == 5'd7) ? 5'd0 : r_cnt + 5'd1;
                end
                ENG_MUL: begin
                    if (r_cnt < 5'd3) begin
                        r_prod <= (ROWS_W + LOG_W)'(mul_a) * (ROWS_W + LOG_W)'(mul_b);
                    end
                    if (r_cnt == 5'd1) begin
                        r_acc <= 63'(r_prod);
                    end else if (r_cnt != 5'd0) begin
                        r_acc <= r_acc - 63'(r_prod);
                    end
                    if (r_cnt == 5'd3) begin
                        r_rem <= ((r_acc - $signed(63'(r_prod))) < 0 ? 60'd0
                                  : 60'(r_acc - $signed(63'(r_prod))))
                                 + (60'(r_m) << (SH - 1));
                        r_dsh <= DSW'(r_m) << (SH + QW - 1);
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                ENG_DIV: begin
                    if (r_rem >= 60'(r_dsh)) begin
                        r_rem <= r_rem - 60'(r_dsh);
                        r_q   <= {r_q[QW-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[QW-2:0], 1'b0};
                    end
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt + 5'd1;
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    assign o_value = r_q;

endmodule

### hdl/binary_column_entropy_sum_core.sv
// top level: stream ports, row count register, running total and result register
//
// Each input word is one matrix column; the core counts its ones over row_count rows
// and adds the binary entropy of that column to a running total. A column with both
// ones and zeros passes the byte-wise popcount, the shared multiplier, the
// one-bit-per-cycle restoring divider and the done state before the input is freed;
// a constant column skips multiplier and divider. The column flagged tlast also
// waits for the previous result word to leave; the core is not ready while a column
// is in work. On that column the total (unsigned, FRAC_BITS fraction bits) leaves on
// the master side and is cleared; tuser flags a clamp of the total since the previous
// result.
module binary_column_entropy_sum_core
    import bce_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ROWS_W-1:0] i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // column_bits
    input  logic              s_axis_tlast,   // last_column
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // total_entropy [28:0], zeros above
    output logic              m_axis_tuser    // saturated
);

    localparam longint unsigned LIM_RAW = longint'(MAX_COLUMNS) << FRAC_BITS;
    localparam longint unsigned ACC_MAX = (64'd1 << ACC_W) - 64'd1;
    localparam logic [ACC_W-1:0] LIMIT  = ACC_W'((LIM_RAW > ACC_MAX) ? ACC_MAX : LIM_RAW);

    logic [ROWS_W-1:0]    r_rows;
    logic                 r_busy, r_last, r_emit, r_ovf, r_ovalid, r_osat;
    logic [ACC_W-1:0]     r_acc, r_odata;
    t_eng_req             eng_req;
    logic                 eng_done;
    logic [FRAC_BITS+1:0] eng_value;
    logic [ACC_W:0]       sum;
    logic                 accept;

    assign s_axis_tready = !r_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign eng_req.start = accept;
    assign eng_req.rows  = r_rows;

    bce_engine #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eng_req),
        .i_bits  (s_axis_tdata),
        .o_done  (eng_done),
        .o_value (eng_value)
    );

    assign sum = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(eng_value);

    // row count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            r_rows <= i_cfg_wdata;
        end
    end

    // column control, running total and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_last   <= 1'b0;
            r_emit   <= 1'b0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_emit && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
                r_odata  <= r_acc;
                r_osat   <= r_ovf;
                r_acc    <= '0;
                r_ovf    <= 1'b0;
                r_emit   <= 1'b0;
                r_busy   <= 1'b0;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (accept) begin
                r_busy <= 1'b1;
                r_last <= s_axis_tlast;
            end
            if (eng_done) begin
                if (sum > (ACC_W + 1)'(LIMIT)) begin
                    r_acc <= LIMIT;
                    r_ovf <= 1'b1;
                end else begin
                    r_acc <= sum[ACC_W-1:0];
                end
                if (r_last) begin
                    r_emit <= 1'b1;
                end else begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(32 - ACC_W){1'b0}}, r_odata};
    assign m_axis_tuser  = r_osat;

    // result word never exceeds the clamp value
    a_out_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ACC_W-1:0] <= LIMIT))
        else $error("result above clamp value");

    // a clamped result sits exactly on the clamp value
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[ACC_W-1:0] == LIMIT))
        else $error("clamp flag without clamp value");

    // engine finishes only while a column is in work
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_done |-> (r_busy && !r_emit))
        else $error("engine done outside a column");

endmodule

### test/tb_binary_column_entropy_sum_core.sv
// testbench for the column entropy sum core: directed and random columns against a predictor
module tb_binary_column_entropy_sum_core
    import bce_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES = 20000;
    localparam int  FRAC         = DEF_FRAC_BITS;
    localparam logic [63:0] TOTAL_CAP =
        ((64'(DEF_MAX_COLUMNS) << FRAC) > 64'h1FFF_FFFF) ? 64'h1FFF_FFFF
                                                         : (64'(DEF_MAX_COLUMNS) << FRAC);

    typedef struct packed {
        logic [ACC_W-1:0] total_entropy;
        logic             saturated;
    } t_total;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ROWS_W-1:0] i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [31:0]       m_axis_tdata;
    logic              m_axis_tuser;

    // predictor state
    logic [ROWS_W-1:0] rows_reg;
    logic [63:0]       run_total;
    logic              run_clamped;
    logic [63:0]       log_lut [0:64];
    t_total            pending_totals [$];
    int                mismatches;
    int                idle_cycles;
    bit                stall_enable;

    binary_column_entropy_sum_core dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // (a * b) >> 62
    function automatic logic [63:0] sq_shift(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // fixed point log2 with 48 fraction bits
    function automatic logic [63:0] fixed_log2(input int x);
        logic [63:0] ex;
        logic [63:0] y;
        logic [63:0] fr;
        ex = 0;
        fr = 0;
        if (x == 0) return 64'd0;
        while (ex < 6 && (64'(x) >> (ex + 1)) != 0) ex++;
        y = 64'(x) << (62 - ex);
        for (int i = 0; i < 48; i++) begin
            y  = sq_shift(y, y);
            fr = fr << 1;
            if (y[63]) begin
                fr = fr | 64'd1;
                y  = y >> 1;
            end
        end
        return (ex << 48) | fr;
    endfunction

    // entropy of one column, rounded to 2^-FRAC
    function automatic logic [63:0] column_entropy_q(input logic [63:0] bits, input int m);
        logic [63:0] msk;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] hm;
        logic [63:0] den;
        int          k;
        msk = (m >= 64) ? '1 : ((64'd1 << m) - 1);
        k   = $countones(bits & msk);
        if (k == 0 || k == m) return 64'd0;
        pos = 64'(m) * log_lut[m];
        neg = 64'(k) * log_lut[k] + 64'(m - k) * log_lut[m - k];
        hm  = (pos > neg) ? pos - neg : 64'd0;
        den = 64'(m) << (48 - FRAC);
        return (hm + den / 2) / den;
    endfunction

    // update running total for one accepted column
    task automatic predict_column(input logic [63:0] bits, input logic last);
        int          m;
        logic [63:0] s;
        t_total      t;
        m = int'(rows_reg);
        if (m < 1) m = 1;
        if (m > 64) m = 64;
        s = run_total + column_entropy_q(bits, m);
        if (s > TOTAL_CAP) begin
            s           = TOTAL_CAP;
            run_clamped = 1'b1;
        end
        run_total = s;
        if (last) begin
            t.total_entropy = s[ACC_W-1:0];
            t.saturated     = run_clamped;
            pending_totals  = {pending_totals, t};
            run_total   = 0;
            run_clamped = 1'b0;
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 3) != 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
    endfunction

    // send one column word
    task automatic send_column(input logic [63:0] bits, input logic last);
        int g;
        g = stall_enable ? gap_len() : 0;
        repeat (g + 1) @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_column(bits, last);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // write row count while idle
    task automatic set_rows(input logic [ROWS_W-1:0] v);
        while (pending_totals.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rows_reg = v;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // random column: sparse, dense, a single one or uniform
    function automatic logic [63:0] weighted_word();
        case ($urandom_range(0, 3))
            0: return rand_word() & rand_word();
            1: return rand_word() | rand_word();
            2: return 64'd1 << $urandom_range(0, 63);
            default: return rand_word();
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_total e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_totals.size() == 0) begin
                $error("unexpected total word %h", m_axis_tdata);
                mismatches++;
            end else begin
                e = pending_totals.pop_front();
                if (m_axis_tdata !== {3'd0, e.total_entropy}) begin
                    $error("total_entropy expected %h actual %h", e.total_entropy, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser !== e.saturated) begin
                    $error("saturated expected %b actual %b", e.saturated, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int g;
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_enable && $urandom_range(0, 4) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // extremes at default rows: all zeros, all ones, single one, half
    task automatic test_default_rows();
        send_column(64'd0, 1'b1);
        send_column('1, 1'b1);
        send_column(64'd1, 1'b0);
        send_column(64'h8000_0000_0000_0000, 1'b0);
        send_column(64'h0000_0000_FFFF_FFFF, 1'b0);
        send_column(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        send_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    endtask

    // row count edge values incl. zero and above the maximum
    task automatic test_row_limits();
        set_rows(7'd1);
        send_column(64'd1, 1'b0);
        send_column(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
        set_rows(7'd2);
        send_column(64'd1, 1'b0);
        send_column(64'hFFFF_FFFF_FFFF_FFFC, 1'b0);
        send_column(64'd2, 1'b1);
        set_rows(7'd0);
        send_column(64'd1, 1'b0);
        send_column(64'd2, 1'b1);
        set_rows(7'd127);
        send_column(64'h5555_5555_5555_5555, 1'b0);
        send_column(64'h0000_0001_0000_0000, 1'b1);
        set_rows(7'd63);
        send_column(64'h8000_0000_0000_0001, 1'b1);
        send_column(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    endtask

    // long matrix of half columns builds a large total
    task automatic test_long_matrix();
        set_rows(7'd64);
        for (int i = 0; i < 1000; i++) begin
            send_column(64'h0000_0000_FFFF_FFFF, i == 999);
        end
        send_column(64'h0000_0000_FFFF_FFFF, 1'b1);
    endtask

    // random matrices over several row counts
    task automatic test_random_matrices();
        int n;
        n = 0;
        stall_enable = 1'b1;
        while (n < 530) begin
            if ($urandom_range(0, 7) == 0) begin
                set_rows($urandom_range(0, 3) == 0 ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(1, 64)));
            end
            for (int c = $urandom_range(1, 30); c > 0; c--) begin
                send_column(weighted_word(), c == 1 || $urandom_range(0, 40) == 0);
                n++;
            end
        end
        stall_enable = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        rows_reg      = ROWS_RESET;
        run_total     = 0;
        run_clamped   = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        stall_enable  = 1'b0;
        for (int x = 0; x <= 64; x++) log_lut[x] = fixed_log2(x);
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_default_rows();
        test_row_limits();
        test_long_matrix();
        test_random_matrices();

        while (pending_totals.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
